// ----- rtl/rsmm_pkg.sv -----
// rsmm_pkg: shared constants, types and the microcode program of the row-sorted matrix median block
// depends on nothing; used by row_sorted_matrix_median_top
`default_nettype none

package rsmm_pkg;

   localparam int unsigned VALUE_W      = 30;
   localparam int unsigned CFG_W        = 6;
   localparam int unsigned DEF_MAX_ROWS = 32;
   localparam int unsigned DEF_MAX_COLS = 32;
   localparam int unsigned CSR_ADDR_W   = 3;
   localparam int unsigned CSR_DATA_W   = 32;

   localparam logic [VALUE_W-1:0] VALUE_TOP = 30'd1000000000;

   // register index, taken from bit 2 of the byte address
   localparam logic REG_ROW_COUNT = 1'b0;
   localparam logic REG_COL_COUNT = 1'b1;

   typedef logic [3:0] upc_type;

   localparam upc_type STEP_IDLE  = 4'd0;
   localparam upc_type STEP_INIT  = 4'd1;
   localparam upc_type STEP_VTEST = 4'd2;
   localparam upc_type STEP_RTEST = 4'd3;
   localparam upc_type STEP_CTEST = 4'd4;
   localparam upc_type STEP_CSTEP = 4'd5;
   localparam upc_type STEP_RNEXT = 4'd6;
   localparam upc_type STEP_VSTEP = 4'd7;
   localparam upc_type STEP_DONE  = 4'd8;

   typedef enum logic [3:0] {
      OP_NONE   = 4'd0,
      OP_INIT   = 4'd1,
      OP_VSTART = 4'd2,
      OP_RSTART = 4'd3,
      OP_READ   = 4'd4,
      OP_CSTEP  = 4'd5,
      OP_RNEXT  = 4'd6,
      OP_VSTEP  = 4'd7,
      OP_EMIT   = 4'd8
   } op_type;

   typedef enum logic [2:0] {
      COND_ALWAYS    = 3'd0,
      COND_START     = 3'd1,
      COND_VAL_DONE  = 3'd2,
      COND_ROWS_DONE = 3'd3,
      COND_COL_DONE  = 3'd4,
      COND_OUT_BUSY  = 3'd5
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      upc_type  on_true;
      upc_type  on_false;
   } uword_type;

   function automatic uword_type ucode_rom(input upc_type addr);
      uword_type w;
      case (addr)
         STEP_IDLE:  w = '{op: OP_NONE,   cond: COND_START,     on_true: STEP_INIT,
                           on_false: STEP_IDLE};
         STEP_INIT:  w = '{op: OP_INIT,   cond: COND_ALWAYS,    on_true: STEP_VTEST,
                           on_false: STEP_VTEST};
         STEP_VTEST: w = '{op: OP_VSTART, cond: COND_VAL_DONE,  on_true: STEP_DONE,
                           on_false: STEP_RTEST};
         STEP_RTEST: w = '{op: OP_RSTART, cond: COND_ROWS_DONE, on_true: STEP_VSTEP,
                           on_false: STEP_CTEST};
         STEP_CTEST: w = '{op: OP_READ,   cond: COND_COL_DONE,  on_true: STEP_RNEXT,
                           on_false: STEP_CSTEP};
         STEP_CSTEP: w = '{op: OP_CSTEP,  cond: COND_ALWAYS,    on_true: STEP_CTEST,
                           on_false: STEP_CTEST};
         STEP_RNEXT: w = '{op: OP_RNEXT,  cond: COND_ALWAYS,    on_true: STEP_RTEST,
                           on_false: STEP_RTEST};
         STEP_VSTEP: w = '{op: OP_VSTEP,  cond: COND_ALWAYS,    on_true: STEP_VTEST,
                           on_false: STEP_VTEST};
         STEP_DONE:  w = '{op: OP_EMIT,   cond: COND_OUT_BUSY,  on_true: STEP_DONE,
                           on_false: STEP_IDLE};
         default:    w = '{op: OP_NONE,   cond: COND_ALWAYS,    on_true: STEP_IDLE,
                           on_false: STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/rsmm_ram.sv -----
// rsmm_ram: generic single-port-write, single-port-read ram with registered read data
// depends on nothing
`default_nettype none

module rsmm_ram #(
   parameter  int unsigned WIDTH  = 30,
   parameter  int unsigned DEPTH  = 1024,
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/row_sorted_matrix_median_top.sv -----
// row_sorted_matrix_median_top: loads a row-sorted matrix and finds its median by value search
// depends on rsmm_pkg and rsmm_ram
//
// usage:
//   csr port (apb style, pready always high): row_count at 0x0, col_count at 0x4, 6 bits each;
//   zero is taken as 1, values above MAX_ROWS / MAX_COLS as that maximum
//   req channel: one element per transfer, row-major, one per cycle while loading;
//   req_is_last ends the matrix and starts the search
//   rsp channel: one transfer per matrix, carrying the median
// search:
//   the search is driven by a microcoded sequencer over one ram read port, with 30 value
//   trials at most; req_ready is low while the search runs
// reset: clears the load position, the sequencer and rsp_valid; both dimensions return to 1;
//   the ram contents are not cleared
// stall: a result waiting on rsp_ready sits in the output register; the next matrix may load
//   meanwhile, and its search waits at the end until the previous result has gone
`default_nettype none

module row_sorted_matrix_median_top #(
   parameter int unsigned MAX_ROWS = rsmm_pkg::DEF_MAX_ROWS,
   parameter int unsigned MAX_COLS = rsmm_pkg::DEF_MAX_COLS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [rsmm_pkg::VALUE_W-1:0]      req_element_value,
   input  wire logic                              req_is_last,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic      [rsmm_pkg::VALUE_W-1:0]      rsp_median_value,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [rsmm_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [rsmm_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [rsmm_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                   csr_pready
);

   localparam int unsigned VW     = rsmm_pkg::VALUE_W;
   localparam int unsigned CW     = rsmm_pkg::CFG_W;
   localparam int unsigned DEPTH  = MAX_ROWS * MAX_COLS;
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned ROW_W  = $clog2(MAX_ROWS + 1);
   localparam int unsigned COL_W  = $clog2(MAX_COLS + 1);
   localparam int unsigned CI_W   = COL_W + 1;
   localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
   localparam int unsigned PROD_W = ROW_W + COL_W;
   localparam int unsigned SUM_W  = ((ADDR_W > COL_W) ? ADDR_W : COL_W) + 1;

   // configuration
   logic [CW-1:0]    row_count_ff, row_count_in;
   logic [CW-1:0]    col_count_ff, col_count_in;
   logic [ROW_W-1:0] rows_eff;
   logic [COL_W-1:0] cols_eff;
   logic [CNT_W-1:0] total;
   logic [CNT_W-1:0] half;
   logic             csr_write;

   // sequencer and datapath
   rsmm_pkg::upc_type   upc_ff, upc_in;
   rsmm_pkg::uword_type uword;
   logic                cond_true;
   logic                out_busy;
   logic                req_xfer;

   logic [CNT_W-1:0]       load_pos_ff, load_pos_in;
   logic [VW-1:0]          vlo_ff, vlo_in;
   logic [VW-1:0]          vhi_ff, vhi_in;
   logic [VW-1:0]          vmid_ff, vmid_in;
   logic [VW:0]            vsum;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [ROW_W-1:0]       row_ff, row_in;
   logic [ADDR_W-1:0]      base_ff, base_in;
   logic signed [CI_W-1:0] col_lo_ff, col_lo_in;
   logic signed [CI_W-1:0] col_hi_ff, col_hi_in;
   logic [COL_W-1:0]       col_mid_ff, col_mid_in;
   logic [COL_W:0]         col_sum;
   logic [COL_W-1:0]       col_mid_now;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]          rsp_value_ff, rsp_value_in;

   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [VW-1:0]     ram_rd_data;

   // csr port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      case (csr_paddr[2])
         rsmm_pkg::REG_ROW_COUNT: csr_prdata = rsmm_pkg::CSR_DATA_W'(row_count_ff);
         rsmm_pkg::REG_COL_COUNT: csr_prdata = rsmm_pkg::CSR_DATA_W'(col_count_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            rsmm_pkg::REG_ROW_COUNT: row_count_in = csr_pwdata[CW-1:0];
            rsmm_pkg::REG_COL_COUNT: col_count_in = csr_pwdata[CW-1:0];
            default: ;
         endcase
      end
   end

   // dimensions in use
   assign rows_eff = (row_count_ff == '0) ? ROW_W'(1) :
                     (32'(row_count_ff) > MAX_ROWS) ? ROW_W'(MAX_ROWS) : ROW_W'(row_count_ff);
   assign cols_eff = (col_count_ff == '0) ? COL_W'(1) :
                     (32'(col_count_ff) > MAX_COLS) ? COL_W'(MAX_COLS) : COL_W'(col_count_ff);
   assign total    = CNT_W'(PROD_W'(rows_eff) * PROD_W'(cols_eff));
   assign half     = total >> 1;

   // handshakes
   assign req_ready        = (upc_ff == rsmm_pkg::STEP_IDLE);
   assign req_xfer         = req_valid & req_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_median_value = rsp_value_ff;
   assign out_busy         = rsp_valid_ff & ~rsp_ready;

   // element store
   assign ram_wr_en = req_xfer & (load_pos_ff < total);

   assign col_sum     = {1'b0, col_lo_ff[COL_W-1:0]} + {1'b0, col_hi_ff[COL_W-1:0]};
   assign col_mid_now = col_sum[COL_W:1];
   assign ram_rd_addr = ADDR_W'(SUM_W'(base_ff) + SUM_W'(col_mid_now));
   assign vsum        = {1'b0, vlo_ff} + {1'b0, vhi_ff};

   rsmm_ram #(
      .WIDTH (VW),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ADDR_W'(load_pos_ff)),
      .wr_data (req_element_value),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // microcode fetch and branch
   assign uword = rsmm_pkg::ucode_rom(upc_ff);

   always_comb begin
      case (uword.cond)
         rsmm_pkg::COND_ALWAYS:    cond_true = 1'b1;
         rsmm_pkg::COND_START:     cond_true = req_xfer & req_is_last;
         rsmm_pkg::COND_VAL_DONE:  cond_true = (vlo_ff > vhi_ff);
         rsmm_pkg::COND_ROWS_DONE: cond_true = (row_ff == rows_eff);
         rsmm_pkg::COND_COL_DONE:  cond_true = (col_lo_ff > col_hi_ff);
         rsmm_pkg::COND_OUT_BUSY:  cond_true = out_busy;
         default:                  cond_true = 1'b0;
      endcase
      upc_in = cond_true ? uword.on_true : uword.on_false;
   end

   // datapath
   always_comb begin
      load_pos_in  = load_pos_ff;
      vlo_in       = vlo_ff;
      vhi_in       = vhi_ff;
      vmid_in      = vmid_ff;
      cnt_in       = cnt_ff;
      row_in       = row_ff;
      base_in      = base_ff;
      col_lo_in    = col_lo_ff;
      col_hi_in    = col_hi_ff;
      col_mid_in   = col_mid_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_value_in = rsp_value_ff;

      if (req_xfer) begin
         if (req_is_last) begin
            load_pos_in = '0;
         end else if (load_pos_ff < CNT_W'(DEPTH)) begin
            load_pos_in = load_pos_ff + CNT_W'(1);
         end
      end

      case (uword.op)
         rsmm_pkg::OP_NONE: ;
         rsmm_pkg::OP_INIT: begin
            vlo_in = VW'(1);
            vhi_in = rsmm_pkg::VALUE_TOP;
         end
         rsmm_pkg::OP_VSTART: begin
            vmid_in = vsum[VW:1];
            cnt_in  = '0;
            row_in  = '0;
            base_in = '0;
         end
         rsmm_pkg::OP_RSTART: begin
            col_lo_in = '0;
            col_hi_in = $signed({1'b0, cols_eff}) - $signed(CI_W'(1));
         end
         rsmm_pkg::OP_READ: begin
            col_mid_in = col_mid_now;
         end
         rsmm_pkg::OP_CSTEP: begin
            // upper-bound step on the entry fetched in the previous cycle
            if (ram_rd_data <= vmid_ff) begin
               col_lo_in = $signed({1'b0, col_mid_ff}) + $signed(CI_W'(1));
            end else begin
               col_hi_in = $signed({1'b0, col_mid_ff}) - $signed(CI_W'(1));
            end
         end
         rsmm_pkg::OP_RNEXT: begin
            cnt_in  = cnt_ff + CNT_W'(col_lo_ff[COL_W-1:0]);
            row_in  = row_ff + ROW_W'(1);
            base_in = base_ff + ADDR_W'(cols_eff);
         end
         rsmm_pkg::OP_VSTEP: begin
            if (cnt_ff <= half) begin
               vlo_in = vmid_ff + VW'(1);
            end else begin
               vhi_in = vmid_ff - VW'(1);
            end
         end
         rsmm_pkg::OP_EMIT: begin
            if (!out_busy) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = vlo_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= CW'(1);
         col_count_ff <= CW'(1);
         upc_ff       <= rsmm_pkg::STEP_IDLE;
         load_pos_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
         upc_ff       <= upc_in;
         load_pos_ff  <= load_pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      vlo_ff       <= vlo_in;
      vhi_ff       <= vhi_in;
      vmid_ff      <= vmid_in;
      cnt_ff       <= cnt_in;
      row_ff       <= row_in;
      base_ff      <= base_in;
      col_lo_ff    <= col_lo_in;
      col_hi_ff    <= col_hi_in;
      col_mid_ff   <= col_mid_in;
      rsp_value_ff <= rsp_value_in;
   end

endmodule

`default_nettype wire
